// ===== rtl/bdlv_pkg.sv =====
// ----------------------------------------------------------------------------
// bdlv_pkg: shared types and constants of the bit dependence link vector unit
// Entry and burst types that the row unit hands to the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

package bdlv_pkg;

	// Default for the largest number of bits analysed
	localparam int MAX_WIDTH_DEF = 32;

	// Q0.16 probability fields
	localparam int PROB_W = 16;

	// Link vector entry: unsigned bit index, all ones is the group separator
	localparam int LV_W = 6;
	localparam logic [LV_W-1:0] LV_SEPARATOR = '1;

	// Width compares run on this many bits (covers bit_width and MAX_WIDTH up to 64)
	localparam int CMP_W = 7;

	// Configuration register map, word index
	localparam logic REG_BIT_WIDTH = 1'b0;
	localparam logic REG_ALPHA     = 1'b1;

	// Reset values of the configuration registers
	localparam logic [5:0]        BIT_WIDTH_RST = 6'd8;
	localparam logic [PROB_W-1:0] ALPHA_RST     = 16'd3277;

	// Result queue
	localparam int BURST_MAX  = 4;
	localparam int FIFO_DEPTH = 16;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_LVL_W = FIFO_PTR_W + 1;
	localparam int BURST_N_W  = 3;

	typedef struct packed {
		logic            last;
		logic [LV_W-1:0] entry;
	} lv_item_t;

	// Entries produced by one finished row, slot 0 first
	typedef struct packed {
		logic [BURST_N_W-1:0]         count;
		lv_item_t [BURST_MAX-1:0]     item;
	} lv_burst_t;

endpackage

`default_nettype wire

// ===== rtl/bdlv_row_unit.sv =====
// ----------------------------------------------------------------------------
// bdlv_row_unit: pair register, dependence test and row bookkeeping
// Registers one (i, j) pair, tests the four context probabilities against the
// marginal and, at the end of each row, forms the link vector entries.
// ----------------------------------------------------------------------------
`default_nettype none

module bdlv_row_unit
	import bdlv_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [5:0]          bit_width,
	input  wire logic [PROB_W-1:0]   alpha_threshold,
	input  wire logic                in_valid,
	input  wire logic                in_ready,
	input  wire logic [5*PROB_W-1:0] in_data,
	output lv_burst_t                burst
);

	localparam int IDX_W = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;

	logic                valid_s1;
	logic [5*PROB_W-1:0] data_s1;

	logic [IDX_W-1:0] row_q;
	logic [IDX_W-1:0] col_q;
	logic             row_dep_q;
	logic             prev_dep_q;

	logic [PROB_W-1:0] prob;
	logic              pair_dep;
	logic              dep;
	logic [CMP_W-1:0]  eff_width;
	logic              row_end;
	logic              last_row;

	function automatic logic far_apart(input logic [PROB_W-1:0] c,
		input logic [PROB_W-1:0] p, input logic [PROB_W-1:0] alpha);
		logic [PROB_W-1:0] d;
		d = (c >= p) ? (c - p) : (p - c);
		return d >= alpha;
	endfunction

	// Register the accepted pair
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid && in_ready;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= in_data;
		end
	end

	// Dependence test on the registered pair
	assign prob     = data_s1[4*PROB_W +: PROB_W];
	assign pair_dep = far_apart(data_s1[0*PROB_W +: PROB_W], prob, alpha_threshold) ||
	                  far_apart(data_s1[1*PROB_W +: PROB_W], prob, alpha_threshold) ||
	                  far_apart(data_s1[2*PROB_W +: PROB_W], prob, alpha_threshold) ||
	                  far_apart(data_s1[3*PROB_W +: PROB_W], prob, alpha_threshold);
	assign dep      = row_dep_q || pair_dep;

	// Clamp the configured width into the supported range
	always_comb begin
		if ({1'b0, bit_width} < CMP_W'(2)) begin
			eff_width = CMP_W'(2);
		end else if ({1'b0, bit_width} > CMP_W'(MAX_WIDTH)) begin
			eff_width = CMP_W'(MAX_WIDTH);
		end else begin
			eff_width = {1'b0, bit_width};
		end
	end

	assign row_end  = (CMP_W'(col_q) + CMP_W'(1)) >= CMP_W'(row_q);
	assign last_row = (CMP_W'(row_q) + CMP_W'(1)) >= eff_width;

	// Form the entries of a finished row
	always_comb begin
		logic [BURST_N_W-1:0] n;
		logic [BURST_N_W-1:0] n_last;
		n      = '0;
		n_last = '0;
		burst  = '0;
		if (valid_s1 && row_end) begin
			if (row_q == IDX_W'(1)) begin
				burst.item[n[1:0]].entry = '0;
				n = n + BURST_N_W'(1);
				burst.item[n[1:0]].entry = LV_SEPARATOR;
				n = n + BURST_N_W'(1);
			end
			if (dep) begin
				burst.item[n[1:0]].entry = LV_W'(row_q);
				n = n + BURST_N_W'(1);
				if (last_row) begin
					burst.item[n[1:0]].entry = LV_SEPARATOR;
					n = n + BURST_N_W'(1);
				end
			end else begin
				if (prev_dep_q) begin
					burst.item[n[1:0]].entry = LV_SEPARATOR;
					n = n + BURST_N_W'(1);
				end
				burst.item[n[1:0]].entry = LV_W'(row_q);
				n = n + BURST_N_W'(1);
				burst.item[n[1:0]].entry = LV_SEPARATOR;
				n = n + BURST_N_W'(1);
			end
			n_last = n - BURST_N_W'(1);
			if (last_row) begin
				burst.item[n_last[1:0]].last = 1'b1;
			end
		end
		burst.count = n;
	end

	// Advance row and column, carry the dependence flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q      <= IDX_W'(1);
			col_q      <= '0;
			row_dep_q  <= 1'b0;
			prev_dep_q <= 1'b0;
		end else if (valid_s1) begin
			if (row_end) begin
				col_q     <= '0;
				row_dep_q <= 1'b0;
				if (last_row) begin
					row_q      <= IDX_W'(1);
					prev_dep_q <= 1'b0;
				end else begin
					row_q      <= row_q + IDX_W'(1);
					prev_dep_q <= dep;
				end
			end else begin
				col_q     <= col_q + IDX_W'(1);
				row_dep_q <= dep;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/bdlv_out_fifo.sv =====
// ----------------------------------------------------------------------------
// bdlv_out_fifo: result queue of link vector entries
// Takes up to four entries a cycle from a finished row and hands out one per
// transfer on the output stream.
// ----------------------------------------------------------------------------
`default_nettype none

module bdlv_out_fifo
	import bdlv_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire lv_burst_t             burst,
	output logic                       room,
	output logic [FIFO_LVL_W-1:0]      level,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output lv_item_t                   out_item
);

	lv_item_t [FIFO_DEPTH-1:0] mem_q;
	logic [FIFO_PTR_W-1:0]     wr_ptr_q;
	logic [FIFO_PTR_W-1:0]     rd_ptr_q;
	logic [FIFO_LVL_W-1:0]     level_q;
	logic                      pop;

	assign out_valid = (level_q != '0);
	assign out_item  = mem_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;
	assign level     = level_q;

	// Leave space for the pair in flight and one more
	assign room = level_q <= FIFO_LVL_W'(FIFO_DEPTH - 2 * BURST_MAX);

	// Store the burst at consecutive slots
	always_ff @(posedge clk) begin
		for (int k = 0; k < BURST_MAX; k++) begin
			if (BURST_N_W'(k) < burst.count) begin
				mem_q[wr_ptr_q + FIFO_PTR_W'(k)] <= burst.item[k];
			end
		end
	end

	// Advance pointers and level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(burst.count);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			level_q <= level_q + FIFO_LVL_W'(burst.count) - FIFO_LVL_W'(pop);
		end
	end

endmodule

`default_nettype wire

// ===== rtl/bit_dependence_link_vector_unit.sv =====
// ----------------------------------------------------------------------------
// bit_dependence_link_vector_unit: streaming link vector of bit dependences
// Path: a row's entries pass the pair register and the result queue before m_axis.
// Throughput: one pair per cycle while the result queue holds 8 or fewer
// entries; output runs at one entry per cycle while m_axis_tready is high and the queue is not empty.
// Reset: row index to 1, column, flags, queue pointers to 0, config to defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module bit_dependence_link_vector_unit
	import bdlv_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,

	// Pair stream in
	input  wire logic                s_axis_tvalid,
	output logic                     s_axis_tready,
	// cpm_given_00, cpm_given_01, cpm_given_10, cpm_given_11, bit_prob
	input  wire logic [5*PROB_W-1:0] s_axis_tdata,

	// Link vector stream out
	output logic                     m_axis_tvalid,
	input  wire logic                m_axis_tready,
	// lv_entry, two zero bits
	output logic [7:0]               m_axis_tdata,
	// end_of_vector
	output logic                     m_axis_tlast,

	// Configuration port
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [2:0]          paddr,
	input  wire logic [31:0]         pwdata,
	output logic [31:0]              prdata,
	output logic                     pready
);

	logic [5:0]           bit_width_q;
	logic [PROB_W-1:0]    alpha_q;
	lv_burst_t            burst;
	logic                 room;
	logic [FIFO_LVL_W-1:0] level;
	lv_item_t             out_item;

	// Configuration registers
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_width_q <= BIT_WIDTH_RST;
			alpha_q     <= ALPHA_RST;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[2])
				REG_BIT_WIDTH: bit_width_q <= pwdata[5:0];
				REG_ALPHA:     alpha_q     <= pwdata[PROB_W-1:0];
				default:       ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_BIT_WIDTH: prdata = {26'd0, bit_width_q};
			REG_ALPHA:     prdata = {16'd0, alpha_q};
			default:       prdata = '0;
		endcase
	end

	// Pair register and row logic
	bdlv_row_unit #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_row (
		.clk            (clk),
		.arst_n         (arst_n),
		.bit_width      (bit_width_q),
		.alpha_threshold(alpha_q),
		.in_valid       (s_axis_tvalid),
		.in_ready       (s_axis_tready),
		.in_data        (s_axis_tdata),
		.burst          (burst)
	);

	// Result queue
	bdlv_out_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.burst    (burst),
		.room     (room),
		.level    (level),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_item (out_item)
	);

	assign s_axis_tready = room;
	assign m_axis_tdata  = {2'b00, out_item.entry};
	assign m_axis_tlast  = out_item.last;

`ifndef ASSERT_OFF
	// Queue level never passes its depth
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level <= FIFO_LVL_W'(FIFO_DEPTH))
		else $error("result queue level above depth");

	// A row's entries always fit into the free queue space
	a_burst_fits: assert property (@(posedge clk) disable iff (!arst_n)
		FIFO_LVL_W'(burst.count) <= (FIFO_LVL_W'(FIFO_DEPTH) - level))
		else $error("row burst overflows result queue");

	// The vector always closes with a separator
	a_last_is_sep: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[LV_W-1:0] == LV_SEPARATOR)
		else $error("end of vector on a non-separator entry");
`endif

endmodule

`default_nettype wire
